@@ hw/rtl/sm3_pkg.sv @@
// SM3 hash engine package: constants, types and round helper functions.
// No dependencies; used by all modules of the engine.
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam logic [255:0] IV =
        256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;

    localparam int QUEUE_DEPTH = 4;

    // Byte request passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } byte_req_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

@@ hw/rtl/sm3_front.sv @@
// SM3 front end: accepts stream requests and queues them for the back end.
// Depends on sm3_pkg.
module sm3_front #(
    parameter int DEPTH = sm3_pkg::QUEUE_DEPTH   // power of two
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte[7:0]
    input  logic               s_tuser,   // has_byte
    input  logic               s_tlast,   // end_of_message
    output logic               q_valid,
    input  logic               q_pop,
    output sm3_pkg::byte_req_t q_req
);
    import sm3_pkg::*;

    localparam int AW = $clog2(DEPTH);

    byte_req_t     mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          push;
    byte_req_t     req;

    // Drop idle items (no byte, no end) at the door
    assign req.data     = s_tdata;
    assign req.has_byte = s_tuser;
    assign req.eom      = s_tlast;
    assign s_tready = (count_reg != (AW+1)'(DEPTH));
    assign push     = s_tvalid && s_tready && (s_tuser || s_tlast);
    assign q_valid  = (count_reg != '0);
    assign q_req    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(q_pop && q_valid);
        end
    end

endmodule

@@ hw/rtl/sm3_back.sv @@
// SM3 back end: block buffer, padding sequencer, one-round-per-cycle compression
// and digest output register. Depends on sm3_pkg.
module sm3_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  sm3_pkg::byte_req_t q_req,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // digest_word[31:0]
    output logic [2:0]         m_tuser,   // word_index[2:0]
    output logic               m_tlast    // last_word
);
    import sm3_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_ROUND, S_OUT
    } state_t;

    state_t        state_reg;
    logic [5:0]    fill_reg;
    logic [63:0]   bits_reg;
    logic [63:0]   len_reg;
    logic          final_reg;      // this message is being padded
    logic          mark_pending_reg; // 0x80 marker not yet written
    logic          len_done_reg;   // length bytes written
    logic [2:0]    len_idx_reg;
    logic [255:0]  chain_reg;
    logic [31:0]   va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg, vh_reg;
    logic [31:0]   w_reg [16];     // rolling schedule window
    logic [5:0]    round_reg;
    logic [2:0]    out_idx_reg;
    logic [31:0]   out_word_reg;
    logic          out_valid_reg;

    logic          byte_wr;
    logic [7:0]    byte_val;
    logic [31:0]   a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
    logic [255:0]  chain_new;

    // Schedule expansion: next word W[j+16]
    assign wn = p1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
              ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];

    // One compression round
    always_comb
    begin
        tj  = (round_reg < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(va_reg, 5'd12);
        ss1 = rotl(a12 + ve_reg + rotl(tj, round_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = va_reg ^ vb_reg ^ vc_reg;
            gg = ve_reg ^ vf_reg ^ vg_reg;
        end
        else
        begin
            ff = (va_reg & vb_reg) | (va_reg & vc_reg) | (vb_reg & vc_reg);
            gg = (ve_reg & vf_reg) | (~ve_reg & vg_reg);
        end
        tt1 = ff + vd_reg + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + vh_reg + ss1 + w_reg[0];
    end

    assign chain_new = chain_reg ^ {tt1, va_reg, rotl(vb_reg, 5'd9), vc_reg,
                                    p0(tt2), ve_reg, rotl(vf_reg, 5'd19), vg_reg};

    // Byte source for the buffer
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    always_comb
    begin
        byte_wr  = 1'b0;
        byte_val = q_req.data;
        unique case (state_reg)
            S_IDLE:
            begin
                byte_wr = q_valid && q_req.has_byte;
            end
            S_PAD:
            begin
                byte_wr  = 1'b1;
                byte_val = mark_pending_reg ? PAD_MARK : 8'h00;
            end
            S_LEN:
            begin
                byte_wr  = 1'b1;
                byte_val = len_reg[63 - 8*len_idx_reg -: 8];
            end
            default:
            begin
                byte_wr = 1'b0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == 3'd7);

    // Block bytes shift into the schedule window as big-endian words
    always_ff @(posedge clk)
    begin
        if (byte_wr)
        begin
            w_reg[fill_reg[5:2]] <= {w_reg[fill_reg[5:2]][23:0], byte_val};
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            bits_reg         <= '0;
            len_reg          <= '0;
            final_reg        <= 1'b0;
            mark_pending_reg <= 1'b0;
            len_done_reg     <= 1'b0;
            len_idx_reg      <= '0;
            chain_reg        <= IV;
            round_reg        <= '0;
            out_idx_reg      <= '0;
            out_word_reg     <= '0;
            out_valid_reg    <= 1'b0;
            {va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg, vh_reg} <= IV;
        end
        else
        begin
            if (byte_wr)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_req.has_byte)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                        end
                        if (q_req.eom)
                        begin
                            final_reg        <= 1'b1;
                            mark_pending_reg <= 1'b1;
                            len_reg <= bits_reg + (q_req.has_byte ? 64'd8 : 64'd0);
                        end
                        if (q_req.has_byte && fill_reg == 6'd63)
                        begin
                            state_reg <= S_ROUND;
                            round_reg <= '0;
                            {va_reg, vb_reg, vc_reg, vd_reg,
                             ve_reg, vf_reg, vg_reg, vh_reg} <= chain_reg;
                        end
                        else if (q_req.eom)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // First pad byte is the marker, the rest are zeros
                    mark_pending_reg <= 1'b0;
                    if (fill_reg == 6'd63)
                    begin
                        state_reg <= S_ROUND;
                        round_reg <= '0;
                        {va_reg, vb_reg, vc_reg, vd_reg,
                         ve_reg, vf_reg, vg_reg, vh_reg} <= chain_reg;
                    end
                    else if (fill_reg == 6'd55)
                    begin
                        state_reg   <= S_LEN;
                        len_idx_reg <= '0;
                    end
                end
                S_LEN:
                begin
                    len_idx_reg <= len_idx_reg + 3'd1;
                    if (len_idx_reg == 3'd7)
                    begin
                        len_done_reg <= 1'b1;
                        state_reg    <= S_ROUND;
                        round_reg    <= '0;
                        {va_reg, vb_reg, vc_reg, vd_reg,
                         ve_reg, vf_reg, vg_reg, vh_reg} <= chain_reg;
                    end
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    {va_reg, vb_reg, vc_reg, vd_reg} <=
                        {tt1, va_reg, rotl(vb_reg, 5'd9), vc_reg};
                    {ve_reg, vf_reg, vg_reg, vh_reg} <=
                        {p0(tt2), ve_reg, rotl(vf_reg, 5'd19), vg_reg};
                    if (round_reg == 6'd63)
                    begin
                        chain_reg <= chain_new;
                        if (!final_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (len_done_reg)
                        begin
                            state_reg     <= S_OUT;
                            out_idx_reg   <= '0;
                            out_word_reg  <= chain_new[255:224];
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        if (out_idx_reg == 3'd7)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                            chain_reg     <= IV;
                            bits_reg      <= '0;
                            final_reg     <= 1'b0;
                            len_done_reg  <= 1'b0;
                        end
                        else
                        begin
                            out_idx_reg  <= out_idx_reg + 3'd1;
                            out_word_reg <= chain_reg[223 - 32*out_idx_reg -: 32];
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/sm3_hash_engine_top.sv @@
// SM3 hash engine: message bytes in on the s_ stream (tuser = byte present,
// tlast = end of message), digest out on the m_ stream as eight 32-bit words,
// word A first, tuser = word index, tlast on the last word. Each full 64-byte
// block is loaded one byte per cycle while bytes are queued, and then passes
// through the one-round-per-cycle compression unit while input waits. At the
// end of a message the padding writes up to 72 bytes at one per cycle (the
// most when 56 bytes are held) with one or two compressions, then eight
// output words, one per cycle while the receiver is ready; new bytes wait
// until the last word is taken. A four-entry queue decouples input acceptance
// from the compression back end.
// Depends on sm3_pkg, sm3_front and sm3_back.
module sm3_hash_engine_top #(
    parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic [2:0]  m_tuser,   // word_index[2:0]
    output logic        m_tlast    // last_word
);
    import sm3_pkg::*;

    logic      q_valid, q_pop;
    byte_req_t q_req;

    sm3_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    sm3_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule
